[hdl/sclru_pkg.sv]
// Shared types and constants of the sector cache LRU controller.
// No dependencies; every other file of the block imports this package.
package sclru_pkg;

  localparam int ENTRIES      = 4;
  localparam int SECTOR_BYTES = 512;
  localparam int AGE_BITS     = 16;

  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int SHIFT    = $clog2(SECTOR_BYTES);
  localparam int LEFT_W   = SHIFT + 1;
  localparam int ADDR_W   = 32;
  localparam int SECTOR_W = 32;
  localparam int FSLOT_W  = 2;
  localparam int OP_W     = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 64;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic [0:0] REG_PARTITION_START = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_FILL_FAIL = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_none;
  } status_t;

  typedef struct packed {
    logic [LEFT_W-1:0]   bytes_left;
    logic [SHIFT-1:0]    byte_offset;
    logic [SECTOR_W-1:0] sector_number;
    logic                write_back;
    logic                evicted;
    logic                fill_needed;
    logic                hit;
    logic [FSLOT_W-1:0]  slot;
  } result_t;

endpackage

[hdl/sclru_ctrl.sv]
// Controller state machine of the sector cache LRU controller.
// Depends on sclru_pkg; drives the datapath through cmd_t.
module sclru_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  sclru_pkg::status_t status,
  output sclru_pkg::cmd_t    cmd
);
  import sclru_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.op_none) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hdl/sclru_dp.sv]
// Datapath of the sector cache LRU controller: input register, tag, valid
// and age store, slot choice, and the result register. Depends on sclru_pkg.
module sclru_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  sclru_pkg::cmd_t              cmd,
  output sclru_pkg::status_t           status,
  input  logic [sclru_pkg::OP_W-1:0]   in_op,
  input  logic [sclru_pkg::ADDR_W-1:0] in_addr,
  input  logic [sclru_pkg::FSLOT_W-1:0] in_fslot,
  input  logic                         cfg_we,
  input  logic [sclru_pkg::CFG_DW-1:0] cfg_wdata,
  output logic [sclru_pkg::CFG_DW-1:0] partition_start,
  output sclru_pkg::result_t           result
);
  import sclru_pkg::*;

  // Registered item; the sector number is formed on the way in.
  op_t                 op_q;
  logic [FSLOT_W-1:0]  fslot_q;
  logic [SECTOR_W-1:0] sector_q;
  logic [SHIFT-1:0]    offset_q;

  logic [SECTOR_W-1:0] slot_tag   [ENTRIES];
  logic [ENTRIES-1:0]  slot_valid;
  logic [AGE_BITS-1:0] slot_age   [ENTRIES];

  logic [ENTRIES-1:0]  hit_vec;
  logic                hit_any;
  logic [SLOT_W-1:0]   hit_idx;
  logic                inv_any;
  logic [SLOT_W-1:0]   inv_idx;
  logic [SLOT_W-1:0]   lru_idx;
  logic [AGE_BITS-1:0] lru_age;
  logic [SLOT_W-1:0]   chosen;
  logic                is_access;
  logic                fslot_ok;
  result_t             res_next;

  assign status.op_none = (op_q == OP_NONE);
  assign is_access      = (op_q == OP_READ) || (op_q == OP_WRITE);
  assign fslot_ok       = ({1'b0, fslot_q} < (FSLOT_W + 1)'(ENTRIES));

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    inv_any = 1'b0;
    inv_idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      hit_vec[k] = slot_valid[k] && (slot_tag[k] == sector_q);
      if (hit_vec[k]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(k);
      end
      if (!slot_valid[k]) begin
        inv_any = 1'b1;
        inv_idx = SLOT_W'(k);
      end
    end
    // Oldest slot; equal ages resolve toward the higher slot.
    lru_idx = '0;
    lru_age = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (slot_age[k] >= lru_age) begin
        lru_age = slot_age[k];
        lru_idx = SLOT_W'(k);
      end
    end
    if (hit_any) begin
      chosen = hit_idx;
    end else if (inv_any) begin
      chosen = inv_idx;
    end else begin
      chosen = lru_idx;
    end
  end

  always_comb begin
    res_next = '0;
    if (is_access) begin
      res_next.slot          = FSLOT_W'(chosen);
      res_next.hit           = hit_any;
      res_next.fill_needed   = !hit_any;
      res_next.evicted       = !hit_any && !inv_any;
      res_next.write_back    = (op_q == OP_WRITE);
      res_next.sector_number = sector_q;
      res_next.byte_offset   = offset_q;
      res_next.bytes_left    = LEFT_W'(SECTOR_BYTES) - LEFT_W'(offset_q);
    end else begin
      res_next.slot = fslot_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_start <= '0;
    end else if (cfg_we) begin
      partition_start <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_NONE;
    end else if (cmd.load_in) begin
      op_q <= op_t'(in_op);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fslot_q  <= in_fslot;
      sector_q <= partition_start + SECTOR_W'(in_addr >> SHIFT);
      offset_q <= in_addr[SHIFT-1:0];
    end
    if (cmd.exec) begin
      result <= res_next;
    end
    if (cmd.exec && is_access && !hit_any) begin
      slot_tag[chosen] <= sector_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        slot_age[k] <= '0;
      end
    end else if (cmd.exec) begin
      if (is_access) begin
        slot_valid[chosen] <= 1'b1;
        for (int k = 0; k < ENTRIES; k++) begin
          if (SLOT_W'(k) == chosen) begin
            slot_age[k] <= '0;
          end else if (slot_valid[k] && slot_age[k] != AGE_MAX) begin
            slot_age[k] <= slot_age[k] + 1'b1;
          end
        end
      end else if (fslot_ok) begin
        slot_valid[SLOT_W'(fslot_q)] <= 1'b0;
        slot_age[SLOT_W'(fslot_q)]   <= '0;
      end
    end
  end

endmodule

[hdl/sector_cache_lru_controller.sv]
// Top level of the sector cache LRU controller: stream ports, APB register
// decode, and the sclru_ctrl / sclru_dp pair. Depends on sclru_pkg.
//
//  Channel   Direction  Handshake              Word contents
//  s_*       in         s_tvalid / s_tready    tuser op, tdata address + failed slot
//  m_*       out        m_tvalid / m_tready    tdata slot, flags, sector, offset, left
//  APB       in/out     psel/penable/pready    partition_start at address 0
//
// Each word is registered in ST_IDLE, forming the absolute sector number (one
// 32-bit add); in ST_EXEC an access compares the four tags, picks the slot and
// updates tags, valid bits and ages, a fill-fail op clears the failed slot, and
// both load the result register. A new word is accepted while a finished result
// still waits on m_*; ST_EXEC stalls only while it waits with m_tready low.
// Reset is synchronous: all slots become invalid with zero ages and
// partition_start returns to zero. A word with op 3 produces no result.
module sector_cache_lru_controller (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [31:0] byte_address, [33:32] failed_slot, [39:34] zero.
  input  logic [sclru_pkg::IN_W-1:0]   s_tdata,
  // [1:0] op.
  input  logic [sclru_pkg::OP_W-1:0]   s_tuser,
  // Result stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [1:0] slot, [2] hit, [3] fill_needed, [4] evicted, [5] write_back,
  // [37:6] sector_number, [46:38] byte_offset, [56:47] bytes_left, [63:57] zero.
  output logic [sclru_pkg::OUT_W-1:0]  m_tdata,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sclru_pkg::CFG_AW-1:0] paddr,
  input  logic [sclru_pkg::CFG_DW-1:0] pwdata,
  output logic [sclru_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import sclru_pkg::*;

  cmd_t                cmd;
  status_t             status;
  result_t             result;
  logic                cfg_we;
  logic [CFG_DW-1:0]   partition_start;

  // One register; bit 2 of the byte address selects the register slot.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_PARTITION_START);

  always_comb begin
    unique case (paddr[2])
      REG_PARTITION_START: prdata = partition_start;
      default:             prdata = '0;
    endcase
  end

  assign m_tdata = OUT_W'(result);

  sclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sclru_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_op           (s_tuser),
    .in_addr         (s_tdata[ADDR_W-1:0]),
    .in_fslot        (s_tdata[ADDR_W+FSLOT_W-1:ADDR_W]),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata),
    .partition_start (partition_start),
    .result          (result)
  );

endmodule

[hdl/sclru_checker.sv]
// Port-level checks of the sector cache LRU controller, bound to the top.
// Depends on sclru_pkg and sector_cache_lru_controller.
module sclru_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [sclru_pkg::OUT_W-1:0]  m_tdata
);
  import sclru_pkg::*;

  // A waiting result holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A hit never asks for a fill or an eviction.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[3] && !m_tdata[4])
    else $error("hit with fill or eviction");

  // An access result has offset plus bytes left equal to one sector.
  a_left: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2] || m_tdata[3]) |->
      (m_tdata[56:47] + LEFT_W'(m_tdata[46:38])) == LEFT_W'(SECTOR_BYTES))
    else $error("offset and bytes left disagree");

  // One word at a time: the cycle after an accept takes no new word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous word in work");

endmodule

bind sector_cache_lru_controller sclru_checker u_sclru_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
